// ===== rtl/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and constants of the software timer slot table: slot entry
// layout, memory request bundle, action and outcome codes, sequencer states.
// ----------------------------------------------------------------------------
package sst_pkg;

    // number of timer slots and derived widths
    localparam int SLOTS  = 16;
    localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IW     = (SW > 4) ? SW : 4;
    // most due slots one scan reports
    localparam int MAXRES = 16;
    localparam int CW     = $clog2(MAXRES + 1);

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_SCAN   = 2'd2,
        ACT_RETIRE = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        OUT_INSERTED    = 3'd0,
        OUT_FULL        = 3'd1,
        OUT_SLOT_DUE    = 3'd2,
        OUT_NONE_DUE    = 3'd3,
        OUT_RETIRED     = 3'd4,
        OUT_NOT_ENABLED = 3'd5
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } state_t;

    // one slot as stored in the table memory
    typedef struct packed {
        logic        en;
        logic [15:0] countdown;
        logic [15:0] period;
        logic [15:0] handler;
    } slot_entry_t;

    // read and write request to the table memory
    typedef struct packed {
        logic          rd_en;
        logic [SW-1:0] rd_addr;
        logic          wr_en;
        logic [SW-1:0] wr_addr;
        slot_entry_t   wr_data;
    } ram_req_t;

    typedef struct packed {
        action_t     action;
        logic [15:0] period;
        logic [15:0] handler_tag;
        logic [3:0]  slot_index;
        logic        keep_running;
    } in_item_t;

    typedef struct packed {
        outcome_t    outcome;
        logic [3:0]  result_slot;
        logic [15:0] due_handler;
        logic        final_item;
    } result_t;

endpackage

// ===== rtl/sst_slot_ram.sv =====
// ----------------------------------------------------------------------------
// sst_slot_ram
// Slot table memory: one write and one read port, registered read data.
// Per-entry written bits make entries read as zero until first written.
// ----------------------------------------------------------------------------
module sst_slot_ram (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sst_pkg::ram_req_t    req,
    output sst_pkg::slot_entry_t rdata
);

    sst_pkg::slot_entry_t mem [sst_pkg::SLOTS];
    sst_pkg::slot_entry_t rd_mem_reg;
    logic [sst_pkg::SLOTS-1:0] written_reg;
    logic                      rd_written_reg;

    // memory array write and read
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_mem_reg <= mem[req.rd_addr];
        end
    end

    // written bits, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                written_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_written_reg <= written_reg[req.rd_addr];
            end
        end
    end

    // unwritten entries read as the reset value
    assign rdata = rd_written_reg ? rd_mem_reg : '0;

endmodule

// ===== rtl/sst_walker.sv =====
// ----------------------------------------------------------------------------
// sst_walker
// Sequencer that walks the slot memory one slot per cycle while no result
// waits on m_tready, for tick, insert and scan, or touches one slot for
// retire; holds the result register and the due result awaiting its last mark.
// ----------------------------------------------------------------------------
module sst_walker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  sst_pkg::in_item_t    s_item,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output sst_pkg::result_t     m_result,
    output sst_pkg::ram_req_t    ram_req,
    input  sst_pkg::slot_entry_t ram_rdata
);

    localparam int SW = sst_pkg::SW;
    localparam int IW = sst_pkg::IW;
    localparam int CW = sst_pkg::CW;

    sst_pkg::state_t   state_reg, state_next;
    sst_pkg::in_item_t item_reg, item_next;
    logic [SW-1:0]     cur_reg, cur_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [3:0]        pend_slot_reg, pend_slot_next;
    logic [15:0]       pend_handler_reg, pend_handler_next;
    logic              out_valid_reg, out_valid_next;
    sst_pkg::result_t  out_reg, out_next;

    logic [IW-1:0]     idx_ext;
    logic [SW-1:0]     start_addr;
    logic [SW-1:0]     nxt_slot;
    logic              last_slot;
    logic              out_free;
    logic              idx_ok;
    logic              due;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sst_pkg::ST_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
            cur_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            cnt_reg        <= cnt_next;
            cur_reg        <= cur_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg         <= item_next;
        pend_slot_reg    <= pend_slot_next;
        pend_handler_reg <= pend_handler_next;
        out_reg          <= out_next;
    end

    assign idx_ext    = IW'(s_item.slot_index);
    assign start_addr = (s_item.action == sst_pkg::ACT_RETIRE) ? idx_ext[SW-1:0] : '0;
    assign nxt_slot   = cur_reg + 1'b1;
    assign last_slot  = (cur_reg == SW'(sst_pkg::SLOTS - 1));
    assign out_free   = !out_valid_reg || m_tready;
    assign idx_ok     = (int'(item_reg.slot_index) < sst_pkg::SLOTS);
    assign due        = ram_rdata.en && (ram_rdata.countdown == 16'd0)
                        && (int'(cnt_reg) < sst_pkg::MAXRES);

    // next state, memory requests and results
    always_comb
    begin
        state_next        = state_reg;
        item_next         = item_reg;
        cur_next          = cur_reg;
        cnt_next          = cnt_reg;
        pend_valid_next   = pend_valid_reg;
        pend_slot_next    = pend_slot_reg;
        pend_handler_next = pend_handler_reg;
        out_next          = out_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        s_tready          = 1'b0;
        ram_req           = '0;

        case (state_reg)
            sst_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    item_next       = s_item;
                    cur_next        = start_addr;
                    cnt_next        = '0;
                    pend_valid_next = 1'b0;
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = start_addr;
                    state_next      = sst_pkg::ST_WALK;
                end
            end

            sst_pkg::ST_WALK:
            begin
                ram_req.wr_addr = cur_reg;
                ram_req.wr_data = ram_rdata;
                case (item_reg.action)
                    sst_pkg::ACT_TICK:
                    begin
                        // decrement enabled nonzero countdowns
                        if (ram_rdata.en && (ram_rdata.countdown != 16'd0))
                        begin
                            ram_req.wr_en             = 1'b1;
                            ram_req.wr_data.countdown = ram_rdata.countdown - 16'd1;
                        end
                        if (last_slot)
                        begin
                            state_next = sst_pkg::ST_IDLE;
                        end
                        else
                        begin
                            ram_req.rd_en   = 1'b1;
                            ram_req.rd_addr = nxt_slot;
                            cur_next        = nxt_slot;
                        end
                    end

                    sst_pkg::ACT_INSERT:
                    begin
                        // claim the lowest free slot, or report full at the end
                        if (!ram_rdata.en || last_slot)
                        begin
                            if (out_free)
                            begin
                                out_valid_next       = 1'b1;
                                out_next.due_handler = 16'd0;
                                out_next.final_item  = 1'b1;
                                if (!ram_rdata.en)
                                begin
                                    ram_req.wr_en             = 1'b1;
                                    ram_req.wr_data.en        = 1'b1;
                                    ram_req.wr_data.countdown = item_reg.period;
                                    ram_req.wr_data.period    = item_reg.period;
                                    ram_req.wr_data.handler   = item_reg.handler_tag;
                                    out_next.outcome          = sst_pkg::OUT_INSERTED;
                                    out_next.result_slot      = 4'(cur_reg);
                                end
                                else
                                begin
                                    out_next.outcome     = sst_pkg::OUT_FULL;
                                    out_next.result_slot = 4'd0;
                                end
                                state_next = sst_pkg::ST_IDLE;
                            end
                        end
                        else
                        begin
                            ram_req.rd_en   = 1'b1;
                            ram_req.rd_addr = nxt_slot;
                            cur_next        = nxt_slot;
                        end
                    end

                    sst_pkg::ACT_SCAN:
                    begin
                        // a new due slot pushes the pending one out as not final
                        if (!(due && pend_valid_reg) || out_free)
                        begin
                            if (due)
                            begin
                                if (pend_valid_reg)
                                begin
                                    out_valid_next       = 1'b1;
                                    out_next.outcome     = sst_pkg::OUT_SLOT_DUE;
                                    out_next.result_slot = pend_slot_reg;
                                    out_next.due_handler = pend_handler_reg;
                                    out_next.final_item  = 1'b0;
                                end
                                pend_valid_next   = 1'b1;
                                pend_slot_next    = 4'(cur_reg);
                                pend_handler_next = ram_rdata.handler;
                                cnt_next          = cnt_reg + 1'b1;
                            end
                            if (last_slot)
                            begin
                                state_next = sst_pkg::ST_FLUSH;
                            end
                            else
                            begin
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = nxt_slot;
                                cur_next        = nxt_slot;
                            end
                        end
                    end

                    sst_pkg::ACT_RETIRE:
                    begin
                        // reload or free the named slot
                        if (out_free)
                        begin
                            out_valid_next       = 1'b1;
                            out_next.result_slot = item_reg.slot_index;
                            out_next.due_handler = 16'd0;
                            out_next.final_item  = 1'b1;
                            if (ram_rdata.en && idx_ok)
                            begin
                                ram_req.wr_en    = 1'b1;
                                out_next.outcome = sst_pkg::OUT_RETIRED;
                                if (item_reg.keep_running)
                                begin
                                    ram_req.wr_data.countdown = ram_rdata.period;
                                end
                                else
                                begin
                                    ram_req.wr_data.en      = 1'b0;
                                    ram_req.wr_data.handler = 16'd0;
                                end
                            end
                            else
                            begin
                                out_next.outcome = sst_pkg::OUT_NOT_ENABLED;
                            end
                            state_next = sst_pkg::ST_IDLE;
                        end
                    end

                    default:
                    begin
                        state_next = sst_pkg::ST_IDLE;
                    end
                endcase
            end

            sst_pkg::ST_FLUSH:
            begin
                // last due slot with its last mark, or the none-due result
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.final_item = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_next.outcome     = sst_pkg::OUT_SLOT_DUE;
                        out_next.result_slot = pend_slot_reg;
                        out_next.due_handler = pend_handler_reg;
                    end
                    else
                    begin
                        out_next.outcome     = sst_pkg::OUT_NONE_DUE;
                        out_next.result_slot = 4'd0;
                        out_next.due_handler = 16'd0;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = sst_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = sst_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_result = out_reg;

endmodule

// ===== rtl/software_timer_slot_table.sv =====
// ----------------------------------------------------------------------------
// software_timer_slot_table
// Table of timer slots with tick, insert, scan and retire commands.
// ----------------------------------------------------------------------------
// Usage
//   The s_ channel carries one command per transaction, the kind in s_tuser.
//   Tick decrements every enabled nonzero countdown and returns nothing.
//   Insert returns one result: the claimed slot or table full.
//   Scan returns every enabled slot with a zero countdown in slot order,
//   the last one marked by m_tlast, or a single none-due result.
//   Retire returns one result and reloads or frees the named slot.
// Timing
//   Slots live in a memory with a registered read; the sequencer walks it
//   one slot per cycle, pausing in insert and scan while a result waits
//   on m_tready. s_tready is high only between commands.
// Reset and stall
//   Reset marks every slot unwritten, so all slots read as free and zero.
//   A stalled m_tready holds the result register; the walk pauses on the
//   slot that has a result to hand over and resumes when it moves.
// ----------------------------------------------------------------------------
module software_timer_slot_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // period[15:0], handler_tag[31:16], slot_index[35:32], keep_running[36]
    input  logic [39:0] s_tdata,
    // action[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // result_slot[3:0], due_handler[19:4]
    output logic [23:0] m_tdata,
    // outcome[2:0]
    output logic [2:0]  m_tuser,
    // final_item
    output logic        m_tlast
);

    sst_pkg::in_item_t    s_item;
    sst_pkg::result_t     m_result;
    sst_pkg::ram_req_t    ram_req;
    sst_pkg::slot_entry_t ram_rdata;

    // unpack the input transaction
    assign s_item.action       = sst_pkg::action_t'(s_tuser);
    assign s_item.period       = s_tdata[15:0];
    assign s_item.handler_tag  = s_tdata[31:16];
    assign s_item.slot_index   = s_tdata[35:32];
    assign s_item.keep_running = s_tdata[36];

    sst_slot_ram u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    sst_walker u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_item    (s_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_result  (m_result),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    // pack the result transaction
    assign m_tdata = {4'd0, m_result.due_handler, m_result.result_slot};
    assign m_tuser = m_result.outcome;
    assign m_tlast = m_result.final_item;

    // one command at a time: busy right after acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
    else $error("command accepted while previous one still in progress");

    // only due-slot results may lack the last mark
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tuser == sst_pkg::OUT_SLOT_DUE))
    else $error("non-final result that is not a due slot");

    // handler tag is only carried by due-slot results
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != sst_pkg::OUT_SLOT_DUE)) |-> (m_tdata[19:4] == 16'd0))
    else $error("handler tag on a result other than slot due");

endmodule
